// ===== rtl/core/hrbd_pkg.sv =====
// Shared types, constants and name tables of the HTTP response body deframer.
package hrbd_pkg;

  localparam int DEFAULT_LENGTH_BITS = 32;
  localparam logic [31:0] DEFAULT_BODY_LENGTH_RESET = 32'd100;

  // Register index of default_body_length; it sits at byte address 4 * index.
  localparam logic REG_DEFAULT_BODY_LENGTH = 1'b0;

  // Header name and value lengths.
  localparam logic [4:0] CL_LEN = 5'd14;
  localparam logic [4:0] TE_LEN = 5'd17;
  localparam logic [3:0] CH_LEN = 4'd8;

  // Stream characters.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // One result of the parser for one stream byte.
  typedef struct packed {
    logic       has_result;
    logic [7:0] body_byte;
    logic       data_valid;
    logic       body_end;
  } result_t;

  // "Content-Length"
  function automatic logic [7:0] cl_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "C";
      5'd1:    c = "o";
      5'd2:    c = "n";
      5'd3:    c = "t";
      5'd4:    c = "e";
      5'd5:    c = "n";
      5'd6:    c = "t";
      5'd7:    c = "-";
      5'd8:    c = "L";
      5'd9:    c = "e";
      5'd10:   c = "n";
      5'd11:   c = "g";
      5'd12:   c = "t";
      5'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Transfer-Encoding"
  function automatic logic [7:0] te_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "T";
      5'd1:    c = "r";
      5'd2:    c = "a";
      5'd3:    c = "n";
      5'd4:    c = "s";
      5'd5:    c = "f";
      5'd6:    c = "e";
      5'd7:    c = "r";
      5'd8:    c = "-";
      5'd9:    c = "E";
      5'd10:   c = "n";
      5'd11:   c = "c";
      5'd12:   c = "o";
      5'd13:   c = "d";
      5'd14:   c = "i";
      5'd15:   c = "n";
      5'd16:   c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // " chunked"
  function automatic logic [7:0] ch_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = " ";
      4'd1:    c = "c";
      4'd2:    c = "h";
      4'd3:    c = "u";
      4'd4:    c = "n";
      4'd5:    c = "k";
      4'd6:    c = "e";
      4'd7:    c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/http_response_body_deframer.sv =====
// Top level of the HTTP response body deframer: handshakes, register port, parser.
//
//   channel   dir  handshake                     payload
//   --------  ---  ----------------------------  ----------------------------------
//   byte      in   byte_valid / byte_stall       rx_byte, new_message
//   result    out  result_valid / result_stall   body_byte, data_valid, body_end
//   apb       in   psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One byte per cycle sustained unless a result is held by result_stall: a byte
// sits in the input register, the parser updates all of its state from it as it
// is consumed, and a result, if any, lands in the output register.
// Reset (rst, synchronous) clears the parser and both handshake stages and sets
// default_body_length to 100. A stalled result blocks only bytes that produce a
// result; bytes that produce none keep advancing under it.
module http_response_body_deframer #(
  parameter int LENGTH_BITS = hrbd_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  input  logic        new_message,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  body_byte,
  output logic        data_valid,
  output logic        body_end,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hrbd_pkg::*;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        held_new;
  logic        advance;
  logic        byte_take;
  logic [31:0] default_body_length;
  result_t     result;

  // Consume the held byte unless its result would overwrite one still waiting.
  assign advance    = held_valid && (!result.has_result || !result_valid || !result_stall);
  assign byte_stall = held_valid && !advance;
  assign byte_take  = byte_valid && !byte_stall;

  // Input register: load on transfer, drop once the parser has used it.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      held_byte <= rx_byte;
      held_new  <= new_message;
    end
  end

  hrbd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .rx_byte             (held_byte),
    .new_message         (held_new),
    .default_body_length (default_body_length),
    .result              (result)
  );

  // Output register: load a new result, otherwise release on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && result.has_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.has_result) begin
      body_byte  <= result.body_byte;
      data_valid <= result.data_valid;
      body_end   <= result.body_end;
    end
  end

  // Register port: one register at paddr[2] == 0; other writes are dropped.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_body_length <= DEFAULT_BODY_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_DEFAULT_BODY_LENGTH) begin
      default_body_length <= pwdata;
    end
  end

  always_comb begin
    if (paddr[2] == REG_DEFAULT_BODY_LENGTH) prdata = default_body_length;
    else prdata = 32'd0;
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    held_valid && !advance |=> held_valid && $stable(held_byte))
    else $error("held byte lost while blocked");

  a_marker_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !data_valid |-> body_end && body_byte == 8'd0)
    else $error("result without payload is not a clean end marker");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall && result.has_result)
    else $error("byte channel stalled without a blocked result");

endmodule

// ===== rtl/core/hrbd_parser.sv =====
// Parser state and single-byte next-state logic of the body deframer.
module hrbd_parser #(
  parameter int LENGTH_BITS = hrbd_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  input  logic             new_message,
  input  logic [31:0]      default_body_length,
  output hrbd_pkg::result_t result
);
  import hrbd_pkg::*;

  localparam int W = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_FIXED  = 3'd1;
  localparam logic [2:0] PH_CSIZE  = 3'd2;
  localparam logic [2:0] PH_CDATA  = 3'd3;
  localparam logic [2:0] PH_CTRAIL = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]             phase, phase_next, phase_start;
  logic                   prev_was_cr, prev_was_cr_next;
  logic                   past_colon, past_colon_next;
  logic                   line_empty, line_empty_next;
  logic [4:0]             name_position, name_position_next;
  logic [3:0]             value_position, value_position_next;
  logic [1:0]             name_match_flags, name_match_flags_next;
  logic                   value_chunked_match, value_chunked_match_next;
  logic [LENGTH_BITS-1:0] number_accumulator, number_accumulator_next;
  logic                   length_found, length_found_next;
  logic                   is_chunked, is_chunked_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic                   hex_stopped, hex_stopped_next;
  logic                   digits_seen, digits_seen_next;
  logic [1:0]             crlf_skip_count, crlf_skip_count_next;

  logic                   num_en, num_hex, do_line_reset;
  logic                   is_ws, is_dec, is_hex_letter;
  logic [3:0]             digit;
  logic [W-1:0]           scaled, acc_sum;
  logic [63:0]            default_wide;
  logic [LENGTH_BITS-1:0] default_len;

  // Fit the 32-bit default into the length width, saturating.
  always_comb begin
    default_wide = {32'b0, default_body_length};
    if ((default_wide >> LENGTH_BITS) != 64'd0) default_len = LEN_MAX;
    else default_len = default_wide[LENGTH_BITS-1:0];
  end

  // Digit decode of the current byte.
  always_comb begin
    is_ws         = (rx_byte == CHAR_SPACE) || (rx_byte >= 8'd9 && rx_byte <= 8'd13);
    is_dec        = (rx_byte >= "0") && (rx_byte <= "9");
    is_hex_letter = ((rx_byte >= "a") && (rx_byte <= "f")) ||
                    ((rx_byte >= "A") && (rx_byte <= "F"));
    digit         = is_dec ? rx_byte[3:0] : rx_byte[3:0] + 4'd9;
  end

  always_comb begin
    phase_start = new_message ? PH_HEADER : phase;
    phase_next  = phase_start;
    if (new_message) begin
      prev_was_cr_next         = 1'b0;
      past_colon_next          = 1'b0;
      line_empty_next          = 1'b1;
      name_position_next       = '0;
      value_position_next      = '0;
      name_match_flags_next    = 2'b11;
      value_chunked_match_next = 1'b1;
      number_accumulator_next  = '0;
      hex_stopped_next         = 1'b0;
      digits_seen_next         = 1'b0;
      length_found_next        = 1'b0;
      is_chunked_next          = 1'b0;
      bytes_remaining_next     = '0;
      crlf_skip_count_next     = '0;
    end else begin
      prev_was_cr_next         = prev_was_cr;
      past_colon_next          = past_colon;
      line_empty_next          = line_empty;
      name_position_next       = name_position;
      value_position_next      = value_position;
      name_match_flags_next    = name_match_flags;
      value_chunked_match_next = value_chunked_match;
      number_accumulator_next  = number_accumulator;
      hex_stopped_next         = hex_stopped;
      digits_seen_next         = digits_seen;
      length_found_next        = length_found;
      is_chunked_next          = is_chunked;
      bytes_remaining_next     = bytes_remaining;
      crlf_skip_count_next     = crlf_skip_count;
    end

    result        = '0;
    num_en        = 1'b0;
    num_hex       = 1'b0;
    do_line_reset = 1'b0;
    scaled        = '0;
    acc_sum       = '0;

    case (phase_start)
      PH_HEADER: begin
        if (prev_was_cr_next && rx_byte == CHAR_LF) begin
          do_line_reset = 1'b1;
          if (line_empty_next) begin
            if (is_chunked_next) begin
              phase_next = PH_CSIZE;
            end else begin
              if (!length_found_next) bytes_remaining_next = default_len;
              if (bytes_remaining_next == '0) begin
                phase_next        = PH_DONE;
                result.has_result = 1'b1;
                result.body_end   = 1'b1;
              end else begin
                phase_next = PH_FIXED;
              end
            end
          end else begin
            if (name_match_flags_next[0] && name_position_next == CL_LEN) begin
              bytes_remaining_next = number_accumulator_next;
              length_found_next    = 1'b1;
            end
            if (name_match_flags_next[1] && name_position_next == TE_LEN &&
                past_colon_next && value_chunked_match_next &&
                value_position_next == CH_LEN)
              is_chunked_next = 1'b1;
          end
        end else begin
          // A lone CR is content; it matches no name and is no digit.
          if (prev_was_cr_next) begin
            prev_was_cr_next = 1'b0;
            if (!past_colon_next) begin
              line_empty_next       = 1'b0;
              name_match_flags_next = 2'b00;
              if (name_position_next != 5'd31) name_position_next = name_position_next + 5'd1;
            end else begin
              value_chunked_match_next = 1'b0;
              if (value_position_next != 4'd15)
                value_position_next = value_position_next + 4'd1;
              if (digits_seen_next) hex_stopped_next = 1'b1;
            end
          end
          if (rx_byte == CHAR_CR) begin
            prev_was_cr_next = 1'b1;
          end else if (!past_colon_next && rx_byte == CHAR_COLON) begin
            past_colon_next = 1'b1;
          end else if (!past_colon_next) begin
            line_empty_next = 1'b0;
            if (name_position_next >= CL_LEN || cl_char(name_position_next) != rx_byte)
              name_match_flags_next[0] = 1'b0;
            if (name_position_next >= TE_LEN || te_char(name_position_next) != rx_byte)
              name_match_flags_next[1] = 1'b0;
            if (name_position_next != 5'd31) name_position_next = name_position_next + 5'd1;
          end else begin
            if (value_position_next >= CH_LEN || ch_char(value_position_next) != rx_byte)
              value_chunked_match_next = 1'b0;
            if (value_position_next != 4'd15) value_position_next = value_position_next + 4'd1;
            num_en = 1'b1;
          end
        end
      end
      PH_FIXED: begin
        result.has_result    = 1'b1;
        result.body_byte     = rx_byte;
        result.data_valid    = 1'b1;
        bytes_remaining_next = bytes_remaining_next - 1'b1;
        if (bytes_remaining_next == '0) begin
          result.body_end = 1'b1;
          phase_next      = PH_DONE;
        end
      end
      PH_CSIZE: begin
        if (prev_was_cr_next && rx_byte == CHAR_LF) begin
          do_line_reset = 1'b1;
          if (number_accumulator_next == '0) begin
            phase_next        = PH_DONE;
            result.has_result = 1'b1;
            result.body_end   = 1'b1;
          end else begin
            bytes_remaining_next = number_accumulator_next;
            phase_next           = PH_CDATA;
          end
        end else begin
          if (prev_was_cr_next) begin
            prev_was_cr_next = 1'b0;
            if (digits_seen_next) hex_stopped_next = 1'b1;
          end
          if (rx_byte == CHAR_CR) prev_was_cr_next = 1'b1;
          else begin
            num_en  = 1'b1;
            num_hex = 1'b1;
          end
        end
      end
      PH_CDATA: begin
        result.has_result    = 1'b1;
        result.body_byte     = rx_byte;
        result.data_valid    = 1'b1;
        bytes_remaining_next = bytes_remaining_next - 1'b1;
        if (bytes_remaining_next == '0) begin
          phase_next           = PH_CTRAIL;
          crlf_skip_count_next = 2'd2;
        end
      end
      PH_CTRAIL: begin
        if (crlf_skip_count_next != 2'd0) crlf_skip_count_next = crlf_skip_count_next - 2'd1;
        if (crlf_skip_count_next == 2'd0) begin
          phase_next    = PH_CSIZE;
          do_line_reset = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Number scan: skip leading whitespace, take digits, stop at the first other byte.
    if (num_en && !hex_stopped_next && !(!digits_seen_next && is_ws)) begin
      if (is_dec || (num_hex && is_hex_letter)) begin
        digits_seen_next = 1'b1;
        if (num_hex) scaled = {number_accumulator_next, 4'b0};
        else scaled = {1'b0, number_accumulator_next, 3'b0} +
                      {3'b0, number_accumulator_next, 1'b0};
        acc_sum = scaled + W'(digit);
        if (acc_sum[W-1:LENGTH_BITS] != 4'd0) number_accumulator_next = LEN_MAX;
        else number_accumulator_next = acc_sum[LENGTH_BITS-1:0];
      end else begin
        hex_stopped_next = 1'b1;
      end
    end

    if (do_line_reset) begin
      prev_was_cr_next         = 1'b0;
      past_colon_next          = 1'b0;
      line_empty_next          = 1'b1;
      name_position_next       = '0;
      value_position_next      = '0;
      name_match_flags_next    = 2'b11;
      value_chunked_match_next = 1'b1;
      number_accumulator_next  = '0;
      hex_stopped_next         = 1'b0;
      digits_seen_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HEADER;
      prev_was_cr         <= 1'b0;
      past_colon          <= 1'b0;
      line_empty          <= 1'b1;
      name_position       <= '0;
      value_position      <= '0;
      name_match_flags    <= 2'b11;
      value_chunked_match <= 1'b1;
      number_accumulator  <= '0;
      length_found        <= 1'b0;
      is_chunked          <= 1'b0;
      bytes_remaining     <= '0;
      hex_stopped         <= 1'b0;
      digits_seen         <= 1'b0;
      crlf_skip_count     <= '0;
    end else if (advance) begin
      phase               <= phase_next;
      prev_was_cr         <= prev_was_cr_next;
      past_colon          <= past_colon_next;
      line_empty          <= line_empty_next;
      name_position       <= name_position_next;
      value_position      <= value_position_next;
      name_match_flags    <= name_match_flags_next;
      value_chunked_match <= value_chunked_match_next;
      number_accumulator  <= number_accumulator_next;
      length_found        <= length_found_next;
      is_chunked          <= is_chunked_next;
      bytes_remaining     <= bytes_remaining_next;
      hex_stopped         <= hex_stopped_next;
      digits_seen         <= digits_seen_next;
      crlf_skip_count     <= crlf_skip_count_next;
    end
  end

  a_fixed_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FIXED |-> bytes_remaining != '0)
    else $error("fixed body phase with no bytes left");

  a_cdata_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CDATA |-> bytes_remaining != '0)
    else $error("chunk data phase with no bytes left");

  a_trail_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CTRAIL |-> crlf_skip_count != 2'd0)
    else $error("chunk trailer phase with empty skip count");

endmodule
